### design/gb2d_pkg.sv
// ----------------------------------------------------------------------------
// gb2d_pkg
// Shared types, constants and helpers for the 2D Gaussian blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package gb2d_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 3;

    localparam int PIX_W     = 16;
    localparam int WGT_W     = 17;
    localparam int ROW_W     = 13;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int RAD_W     = 2;
    localparam int OROW_W    = 12;
    localparam int OCOL_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 15;
    localparam int PROD_W    = 2 * WGT_W;
    localparam int TERM_W    = PIX_W + WGT_W;

    localparam logic [ROW_W-1:0] ROW_MAX    = {ROW_W{1'b1}};
    localparam logic [WGT_W-1:0] WGT_ONE    = 17'd65536;
    localparam logic [PIX_W-1:0] PIX_MAX    = {PIX_W{1'b1}};
    localparam int               ROUND_HALF = 32768;
    localparam int               Q_SHIFT    = 16;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_KERNEL_RAD   = 3'd2,
        CFG_WEIGHT_C     = 3'd3,
        CFG_WEIGHT_1     = 3'd4,
        CFG_WEIGHT_2     = 3'd5,
        CFG_WEIGHT_3     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MAC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic col_shift;
        logic load;
        logic rotate;
    } t_cell_ctl;

    function automatic logic [WGT_W-1:0] clamp_weight(input logic [WGT_W-1:0] w);
        return (w > WGT_ONE) ? WGT_ONE : w;
    endfunction

endpackage

`default_nettype wire

### design/gb2d_cell.sv
// ----------------------------------------------------------------------------
// gb2d_cell
// One window cell: holds a pixel, takes a column shift, a line-store load or
// a rotate step from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2d_cell
    import gb2d_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [PIX_W-1:0] i_shift_d,
    input  wire logic [PIX_W-1:0] i_load_d,
    input  wire logic [PIX_W-1:0] i_rot_d,
    output logic      [PIX_W-1:0] o_q
);

    logic [PIX_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.col_shift) begin
            r_q <= i_shift_d;
        end else if (i_ctl.load) begin
            r_q <= i_load_d;
        end else if (i_ctl.rotate) begin
            r_q <= i_rot_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

### design/gb2d_mac.sv
// ----------------------------------------------------------------------------
// gb2d_mac
// Pipelined multiply-accumulate: weight pair product, Q16 rounding of the
// coefficient, pixel product, running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2d_mac
    import gb2d_pkg::*;
#(
    parameter int ACC_W = 38
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_valid,
    input  wire logic [PIX_W-1:0] i_pix,
    input  wire logic [WGT_W-1:0] i_wy,
    input  wire logic [WGT_W-1:0] i_wx,
    output logic      [ACC_W-1:0] o_acc
);

    logic [PIX_W-1:0]  r_s1_pix;
    logic [PROD_W-1:0] r_s1_prod;
    logic [TERM_W-1:0] r_s2_term;
    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W:0]   coef_sum;
    logic [WGT_W-1:0]  coef;

    assign coef_sum = {1'b0, r_s1_prod} + (PROD_W+1)'(ROUND_HALF);
    assign coef     = coef_sum[Q_SHIFT +: WGT_W];

    // drop the pixel of a masked tap so stale window data never reaches the sum
    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_valid ? i_pix : '0;
        r_s1_prod <= i_valid ? (i_wy * i_wx) : '0;
        r_s2_term <= r_s1_pix * coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + ACC_W'(r_s2_term);
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### design/gaussian_blur_2d_conv.sv
// ----------------------------------------------------------------------------
// gaussian_blur_2d_conv
// Zero-padded (2R+1)x(2R+1) Gaussian blur over a raster pixel stream.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tdata pixel, tuser req_type
// m_axis    out        m_axis_tvalid/tready      tdata pixel/row/col, tlast, tuser
// cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item at a time: accept, line-store reads of the new window column and
// MAC steps over the N x N window (N = 2*MAX_RADIUS+1), then the output register.
// The single line-store read port and the one shared multiplier chain keep the
// block from taking a new item before the last one is through.
// Synchronous active-low reset clears counters, window and config defaults;
// the line store needs no clearing. A stalled output holds the block in S_OUT.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_2d_conv
    import gb2d_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [PIX_W-1:0]     s_axis_tdata,  // [15:0] pixel_value
    input  wire logic                 s_axis_tuser,  // [0] req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [39:0]               m_axis_tdata,  // [15:0] out_pixel, [27:16] out_row,
                                                     // [37:28] out_col, [39:38] zero
    output logic                      m_axis_tlast,  // last_of_run
    output logic                      m_axis_tuser,  // [0] frame_done
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WGT_W-1:0]     i_cfg_data
);

    localparam int N     = 2 * MAX_RADIUS + 1;
    localparam int NC    = N * N;
    localparam int AW    = $clog2(2 * MAX_RADIUS * MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int JW    = $clog2(N);
    localparam int RCW   = $clog2(N + 1);
    localparam int MCW   = $clog2(NC + 3);
    localparam int ACC_W = TERM_W + $clog2(NC);

    // configuration
    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [RAD_W-1:0] r_rad;
    logic [WGT_W-1:0] r_wc, r_w1, r_w2, r_w3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= FW_W'(1024);
            r_fh  <= FH_W'(1024);
            r_rad <= RAD_W'(3);
            r_wc  <= WGT_W'(26155);
            r_w1  <= WGT_W'(15862);
            r_w2  <= WGT_W'(3540);
            r_w3  <= WGT_W'(290);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_fw  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_fh  <= i_cfg_data[FH_W-1:0];
                CFG_KERNEL_RAD:   r_rad <= i_cfg_data[RAD_W-1:0];
                CFG_WEIGHT_C:     r_wc  <= i_cfg_data;
                CFG_WEIGHT_1:     r_w1  <= i_cfg_data;
                CFG_WEIGHT_2:     r_w2  <= i_cfg_data;
                CFG_WEIGHT_3:     r_w3  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic [JW-1:0]   eff_r;

    always_comb begin
        if (r_fw == '0) begin
            eff_w = CW'(1);
        end else if (int'(r_fw) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(r_fw);
        end
        eff_h = (r_fh == '0) ? FH_W'(1) : r_fh;
        eff_r = (int'(r_rad) > MAX_RADIUS) ? JW'(MAX_RADIUS) : JW'(r_rad);
    end

    // state
    t_state r_state, n_state;
    logic   accept;
    logic   rotate, load_col, mac_clear;

    logic [ROW_W-1:0]        r_row, n_row;
    logic [CW-1:0]           r_col, n_col;
    logic [AW-1:0]           r_ptr, r_rd_addr;
    logic [PIX_W-1:0]        r_rd_data;
    logic [RCW-1:0]          r_rd_cnt;
    logic [MCW-1:0]          r_mac_cnt;
    logic [JW-1:0]           r_tj, r_ti;
    logic signed [POS_W-1:0] r_cy, r_cx;
    logic                    r_emit, r_fd;
    logic [PIX_W-1:0]        r_res;

    logic [PIX_W-1:0] mem [2**AW];

    assign accept = s_axis_tvalid && s_axis_tready;

    // position bookkeeping for the accepted item
    logic [ROW_W-1:0]        row0;
    logic [CW-1:0]           col0;
    logic                    in_frame;
    logic [PIX_W-1:0]        value;
    logic signed [POS_W-1:0] cys, cxs, hs, ws;
    logic                    pge, emit, fd;

    always_comb begin
        if (r_col >= eff_w) begin
            col0 = '0;
            row0 = (r_row == ROW_MAX) ? r_row : r_row + ROW_W'(1);
        end else begin
            col0 = r_col;
            row0 = r_row;
        end
        in_frame = row0 < {1'b0, eff_h};
        value    = (!s_axis_tuser && in_frame) ? s_axis_tdata : '0;
        hs  = $signed(POS_W'(eff_h));
        ws  = $signed(POS_W'(eff_w));
        cxs = $signed(POS_W'(col0));
        cys = $signed(POS_W'(row0)) - $signed(POS_W'(eff_r));
        // step back R positions with borrow into the row
        for (int t = 0; t < MAX_RADIUS; t++) begin
            if (t < int'(eff_r)) begin
                if (cxs == '0) begin
                    cxs = ws - POS_W'(1);
                    cys = cys - POS_W'(1);
                end else begin
                    cxs = cxs - POS_W'(1);
                end
            end
        end
        pge  = cys >= 0;
        emit = pge && (cys < hs);
        fd   = emit && (cys == hs - POS_W'(1)) && (cxs == ws - POS_W'(1));
        if (fd || (pge && !emit)) begin
            n_row = '0;
            n_col = '0;
        end else if (col0 + CW'(1) >= eff_w) begin
            n_col = '0;
            n_row = (row0 == ROW_MAX) ? row0 : row0 + ROW_W'(1);
        end else begin
            n_col = col0 + CW'(1);
            n_row = row0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ptr <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
            r_ptr <= r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cy   <= cys;
            r_cx   <= cxs;
            r_emit <= emit;
            r_fd   <= fd;
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_ptr + AW'(1)] <= value;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_addr <= r_ptr + AW'(1);
        end else if (r_state == S_READ) begin
            r_rd_addr <= r_rd_addr - AW'(eff_w);
        end
    end

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= '0;
            r_mac_cnt <= '0;
            r_tj      <= '0;
            r_ti      <= '0;
        end else begin
            if (accept) begin
                r_rd_cnt <= '0;
            end else if (r_state == S_READ) begin
                r_rd_cnt <= r_rd_cnt + RCW'(1);
            end
            if (r_state == S_MAC) begin
                r_mac_cnt <= r_mac_cnt + MCW'(1);
            end else begin
                r_mac_cnt <= '0;
            end
            if (r_state != S_MAC) begin
                r_tj <= '0;
                r_ti <= '0;
            end else if (rotate) begin
                if (r_ti == JW'(N - 1)) begin
                    r_ti <= '0;
                    r_tj <= r_tj + JW'(1);
                end else begin
                    r_ti <= r_ti + JW'(1);
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: if (r_rd_cnt == RCW'(N)) n_state = S_MAC;
            S_MAC: begin
                if (r_mac_cnt == MCW'(NC + 2)) begin
                    n_state = r_emit ? S_OUT : S_IDLE;
                end
            end
            S_OUT: if (!m_axis_tvalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        load_col      = (r_state == S_READ) && (r_rd_cnt != '0);
        rotate        = (r_state == S_MAC) && (r_mac_cnt < MCW'(NC));
        mac_clear     = (r_state != S_MAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window chain
    logic [PIX_W-1:0] cell_q [NC];

    for (genvar j = 0; j < N; j++) begin : g_row
        for (genvar i = 0; i < N; i++) begin : g_col
            localparam int IDX = j * N + i;
            t_cell_ctl        ctl;
            logic [PIX_W-1:0] shift_d;

            assign ctl.col_shift = accept;
            assign ctl.rotate    = rotate;
            if (i == 0) begin : g_edge
                assign shift_d  = '0;
                assign ctl.load = load_col && (r_rd_cnt == RCW'(j + 1));
            end else begin : g_inner
                assign shift_d  = cell_q[IDX-1];
                assign ctl.load = 1'b0;
            end

            gb2d_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (ctl),
                .i_shift_d(shift_d),
                .i_load_d (r_rd_data),
                .i_rot_d  (cell_q[(IDX + 1) % NC]),
                .o_q      (cell_q[IDX])
            );
        end
    end

    // tap weights and in-frame test for the head of the chain
    logic signed [POS_W-1:0] ny, nx, rs;
    logic [JW-1:0]           oy, ox;
    logic [WGT_W-1:0]        wy, wx;
    logic                    tap_ok;

    function automatic logic [WGT_W-1:0] pick_weight(
        input logic [JW-1:0]    off,
        input logic [WGT_W-1:0] w0,
        input logic [WGT_W-1:0] w1,
        input logic [WGT_W-1:0] w2,
        input logic [WGT_W-1:0] w3
    );
        logic [WGT_W-1:0] w;
        if (off == JW'(0)) begin
            w = w0;
        end else if (off == JW'(1)) begin
            w = w1;
        end else if (int'(off) == 2) begin
            w = w2;
        end else begin
            w = w3;
        end
        return clamp_weight(w);
    endfunction

    always_comb begin
        rs = $signed(POS_W'(eff_r));
        ny = r_cy + rs - $signed(POS_W'(r_tj));
        nx = r_cx + rs - $signed(POS_W'(r_ti));
        oy = (r_tj > eff_r) ? r_tj - eff_r : eff_r - r_tj;
        ox = (r_ti > eff_r) ? r_ti - eff_r : eff_r - r_ti;
        wy = pick_weight(oy, r_wc, r_w1, r_w2, r_w3);
        wx = pick_weight(ox, r_wc, r_w1, r_w2, r_w3);
        tap_ok = rotate
              && (int'(r_tj) <= 2 * int'(eff_r)) && (int'(r_ti) <= 2 * int'(eff_r))
              && (ny >= 0) && (ny < $signed(POS_W'(eff_h)))
              && (nx >= 0) && (nx < $signed(POS_W'(eff_w)));
    end

    logic [ACC_W-1:0] acc;

    gb2d_mac #(
        .ACC_W(ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_clear(mac_clear),
        .i_valid(tap_ok),
        .i_pix  (cell_q[0]),
        .i_wy   (wy),
        .i_wx   (wx),
        .o_acc  (acc)
    );

    // round and saturate
    logic [ACC_W:0] acc_rnd;
    logic [ACC_W:0] acc_q;

    assign acc_rnd = {1'b0, acc} + (ACC_W+1)'(ROUND_HALF);
    assign acc_q   = acc_rnd >> Q_SHIFT;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAC && r_mac_cnt == MCW'(NC + 2)) begin
            r_res <= (acc_q > (ACC_W+1)'(PIX_MAX)) ? PIX_MAX : acc_q[PIX_W-1:0];
        end
    end

    // output register
    logic             r_m_valid, r_m_fd;
    logic [PIX_W-1:0] r_m_pix;
    logic [OROW_W-1:0] r_m_row;
    logic [OCOL_W-1:0] r_m_col;
    logic              out_load;

    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_pix <= r_res;
            r_m_row <= OROW_W'(r_cy);
            r_m_col <= OCOL_W'(r_cx);
            r_m_fd  <= r_fd;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_col, r_m_row, r_m_pix};
    assign m_axis_tlast  = 1'b1;
    assign m_axis_tuser  = r_m_fd;

    // checks
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ))
        else $error("accepted item did not start line-store reads");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rd_cnt <= RCW'(N)))
        else $error("read counter ran past window height");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the output state");

    a_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_mac_cnt == MCW'(NC + 2) && !r_emit) |=> (r_state == S_IDLE))
        else $error("item without result reached the output state");

endmodule

`default_nettype wire

### tb/gaussian_blur_2d_conv_test.sv
// ----------------------------------------------------------------------------
// gaussian_blur_2d_conv_test
// Self-checking bench for the streaming Gaussian blur. Whole frames are sent,
// each one followed by flush items until its last pixel drains. A directed
// table runs first, then random small frames, then a few extreme frame sizes.
// Every output item is compared field by field with a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_2d_conv_test;
    import gb2d_pkg::*;

    localparam int HIST_DEPTH = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF + 2 * MAX_RADIUS_DEF + 1;
    localparam int ROW_CAP    = 8191;
    localparam int SETTLE     = 80;
    localparam int QUIET_MAX  = 1000;

    typedef struct {
        logic [15:0] pix;
        logic [11:0] row;
        logic [9:0]  col;
        logic        done;
    } blur_out_t;

    typedef struct {
        int          set;
        logic        flush;
        logic [15:0] pix;
        bit          typed;
        logic [15:0] exp_pix;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WGT_W-1:0] i_cfg_data = '0;

    gaussian_blur_2d_conv uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0]  hist [HIST_DEPTH];
    int unsigned  hist_ptr = 0;
    int unsigned  row_pos = 0;
    int unsigned  col_pos = 0;
    logic [10:0]  frm_w = 11'd1024;
    logic [11:0]  frm_h = 12'd1024;
    logic [1:0]   krad = 2'd3;
    logic [16:0]  wgt [4] = '{17'd26155, 17'd15862, 17'd3540, 17'd290};

    blur_out_t    blur_q[$];
    int           err_count = 0;
    bit           calm = 1'b0;
    int           quiet = 0;
    int           stall_left = 0;

    function automatic longint unsigned wgt_at(int off);
        return (wgt[off] > 17'd65536) ? 65536 : wgt[off];
    endfunction

    function automatic int unsigned eff_w();
        int unsigned w;
        w = (frm_w == 0) ? 1 : frm_w;
        return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    endfunction

    function automatic int unsigned eff_h();
        return (frm_h == 0) ? 1 : frm_h;
    endfunction

    function automatic void blur_step(input logic flush, input logic [15:0] px);
        int unsigned w, h, r, total, lag, p, q, cy, cx, d, addr;
        int ny, nx;
        longint unsigned acc, coef, res;
        blur_out_t o;
        w = eff_w();
        h = eff_h();
        r = krad;
        if (col_pos >= w) begin
            col_pos = 0;
            if (row_pos < ROW_CAP) row_pos++;
        end
        total = w * h;
        lag = r * w + r;
        p = row_pos * w + col_pos;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        hist[hist_ptr] = (!flush && p < total) ? px : 16'd0;
        if (p >= lag && p - lag < total) begin
            q = p - lag;
            cy = q / w;
            cx = q % w;
            acc = 0;
            for (int ky = -int'(r); ky <= int'(r); ky++) begin
                ny = int'(cy) + ky;
                if (ny < 0 || ny >= int'(h)) continue;
                for (int kx = -int'(r); kx <= int'(r); kx++) begin
                    nx = int'(cx) + kx;
                    if (nx < 0 || nx >= int'(w)) continue;
                    coef = (wgt_at(ky < 0 ? -ky : ky) * wgt_at(kx < 0 ? -kx : kx) + 32768) >> 16;
                    d = p - (ny * w + nx);
                    if (d >= HIST_DEPTH) continue;
                    addr = (hist_ptr + HIST_DEPTH - d) % HIST_DEPTH;
                    acc += hist[addr] * coef;
                end
            end
            res = (acc + 32768) >> 16;
            o.pix = (res > 65535) ? 16'hFFFF : res[15:0];
            o.row = cy[11:0];
            o.col = cx[9:0];
            o.done = (q == total - 1);
            blur_q.push_back(o);
            if (o.done) begin
                row_pos = 0;
                col_pos = 0;
                return;
            end
        end else if (p >= lag) begin
            row_pos = 0;
            col_pos = 0;
            return;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            if (row_pos < ROW_CAP) row_pos++;
        end
    endfunction

    task automatic report(input string what, input longint got, input longint exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        err_count++;
    endtask

    // valid stays high between back-to-back items; here it drops only for a gap
    task automatic send_item(input logic flush, input logic [15:0] px);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= flush;
        do @(posedge i_clk); while (!s_axis_tready);
        blur_step(flush, px);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:  frm_w = val[10:0];
            CFG_FRAME_HEIGHT: frm_h = val[11:0];
            CFG_KERNEL_RAD:   krad = val[1:0];
            CFG_WEIGHT_C:     wgt[0] = val;
            CFG_WEIGHT_1:     wgt[1] = val;
            CFG_WEIGHT_2:     wgt[2] = val;
            CFG_WEIGHT_3:     wgt[3] = val;
            default: ;
        endcase
    endtask

    // hold input until every result is out, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h, input int r,
                             input int w0, input int w1,
                             input int w2, input int w3);
        drain();
        cfg_write(CFG_FRAME_WIDTH, 17'(w));
        cfg_write(CFG_FRAME_HEIGHT, 17'(h));
        cfg_write(CFG_KERNEL_RAD, 17'(r));
        cfg_write(CFG_WEIGHT_C, 17'(w0));
        cfg_write(CFG_WEIGHT_1, 17'(w1));
        cfg_write(CFG_WEIGHT_2, 17'(w2));
        cfg_write(CFG_WEIGHT_3, 17'(w3));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_wgt();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65536;
            2: return int'($urandom_range(65537, 131071));
            default: return int'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [15:0] rand_pix();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // full frame, then flushes (with stray pixels) until the last result drains
    task automatic run_frame(output int sent);
        int unsigned total, lag;
        logic flush;
        total = eff_w() * eff_h();
        lag = krad * eff_w() + krad;
        sent = total + lag;
        for (int i = 0; i < sent; i++) begin
            if (i < total) flush = ($urandom_range(0, 11) == 0);
            else flush = ($urandom_range(0, 3) != 0);
            send_item(flush, rand_pix());
        end
    endtask

    stim_row_t dir_tab[] = '{
        '{0, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF},
        '{0, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{0, 1'b1, 16'hABCD, 1'b1, 16'h0000},  // flush inside the frame reads as zero
        '{0, 1'b0, 16'h0001, 1'b1, 16'h0001},
        '{0, 1'b0, 16'h8000, 1'b1, 16'h8000},
        '{1, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
        '{1, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
        '{1, 1'b0, 16'h3039, 1'b0, 16'h0000},  // pixel past frame end, ignored
        '{1, 1'b0, 16'h5555, 1'b0, 16'h0000},
        '{1, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{2, 1'b0, 16'h1234, 1'b0, 16'h0000},
        '{2, 1'b0, 16'hFEDC, 1'b0, 16'h0000},
        '{2, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{2, 1'b0, 16'h0F0F, 1'b0, 16'h0000},
        '{2, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{2, 1'b1, 16'h0000, 1'b0, 16'h0000},
        '{2, 1'b1, 16'h0000, 1'b0, 16'h0000}
    };

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        blur_out_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blur_q.size() == 0) begin
                report("unexpected item, row", m_axis_tdata[27:16], -1);
            end else begin
                e = blur_q.pop_front();
                if (m_axis_tdata[15:0] !== e.pix) report("out_pixel", m_axis_tdata[15:0], e.pix);
                if (m_axis_tdata[27:16] !== e.row) report("out_row", m_axis_tdata[27:16], e.row);
                if (m_axis_tdata[37:28] !== e.col) report("out_col", m_axis_tdata[37:28], e.col);
                if (m_axis_tdata[39:38] !== 2'b00) report("tdata pad", m_axis_tdata[39:38], 0);
                if (m_axis_tlast !== 1'b1) report("last_of_run", m_axis_tlast, 1);
                if (m_axis_tuser !== e.done) report("frame_done", m_axis_tuser, e.done);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int cur_set;
        int random_items;
        int n;
        for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 16'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_set = -1;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].set != cur_set) begin
                cur_set = dir_tab[i].set;
                case (cur_set)
                    0: set_frame(1, 1, 0, 65536, 0, 0, 0);
                    1: set_frame(2, 1, 1, 65536, 65536, 65536, 65536);
                    default: set_frame(2, 2, 1, 26155, 15862, 3540, 290);
                endcase
            end
            n = blur_q.size();
            send_item(dir_tab[i].flush, dir_tab[i].pix);
            if (dir_tab[i].typed && blur_q.size() > n) blur_q[$].pix = dir_tab[i].exp_pix;
        end

        random_items = 0;
        while (random_items < 60) begin
            case ($urandom_range(0, 9))
                0: set_frame(0, 0, $urandom_range(0, 3),
                             rand_wgt(), rand_wgt(), rand_wgt(), rand_wgt());
                default: set_frame($urandom_range(1, 8), $urandom_range(1, 6),
                                   $urandom_range(0, 3),
                                   rand_wgt(), rand_wgt(), rand_wgt(), rand_wgt());
            endcase
            run_frame(n);
            random_items += n;
        end

        calm = 1'b1;
        set_frame(0, 0, 3, 131071, 131071, 131071, 131071);
        run_frame(n);
        set_frame(3, 2, 3, 65536, 65536, 65536, 65536);
        run_frame(n);

        drain();
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
